FILE: rtl/mswh_pkg.sv
// ----------------------------------------------------------------------------
// mswh_pkg
// shared types and constants of the word-serial murmur-style hash
// ----------------------------------------------------------------------------
package mswh_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int HASH_W  = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] MUL_K1 = 64'h87c3_7b91_1142_53d5;
  localparam logic [WORD_W-1:0] MUL_K2 = 64'h4cf5_ad43_2745_937f;
  localparam logic [WORD_W-1:0] ADD_H  = 64'h0000_0000_52dc_e729;
  localparam logic [WORD_W-1:0] FIN_M1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [WORD_W-1:0] FIN_M2 = 64'hc4ce_b9fe_1a85_ec53;

  localparam int ROT_K     = 31;
  localparam int ROT_H     = 27;
  localparam int FIN_SHIFT = 33;

  localparam logic [CFG_W-1:0] SEED_RESET = 32'h0000_0000;
  localparam logic [CFG_W-1:0] LEN_RESET  = 32'h0001_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 1'b1;

  // which constant the shared multiplier works against
  typedef enum logic [1:0] {
    SEL_K1,
    SEL_K2,
    SEL_M1,
    SEL_M2
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_KROT,
    OP_HUPD,
    OP_FINA,
    OP_FINB,
    OP_FOUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_KROT,
    ST_HUPD,
    ST_FINA,
    ST_FINB,
    ST_FOUT
  } state_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } dp_sts_t;

endpackage

FILE: rtl/mswh_ctrl.sv
// ----------------------------------------------------------------------------
// mswh_ctrl
// sequencer: steps the shared multiplier through mix and finalizer
// ----------------------------------------------------------------------------
module mswh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mswh_pkg::dp_sts_t sts,
  output mswh_pkg::dp_cmd_t cmd
);
  import mswh_pkg::*;

  state_t   state_r, state_nxt;
  mul_sel_t mul_sel_r, mul_sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mul_sel_r <= SEL_K1;
    end else begin
      state_r   <= state_nxt;
      mul_sel_r <= mul_sel_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    mul_sel_nxt = mul_sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = ST_MUL0;
          mul_sel_nxt = SEL_K1;
        end
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: begin
        unique case (mul_sel_r)
          SEL_K1: state_nxt = ST_KROT;
          SEL_K2: state_nxt = ST_HUPD;
          SEL_M1: state_nxt = ST_FINB;
          SEL_M2: state_nxt = ST_FOUT;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_KROT: begin
        state_nxt   = ST_MUL0;
        mul_sel_nxt = SEL_K2;
      end
      ST_HUPD: state_nxt = sts.last ? ST_FINA : ST_IDLE;
      ST_FINA: begin
        state_nxt   = ST_MUL0;
        mul_sel_nxt = SEL_M1;
      end
      ST_FINB: begin
        state_nxt   = ST_MUL0;
        mul_sel_nxt = SEL_M2;
      end
      ST_FOUT: begin
        if (!sts.out_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.sel  = mul_sel_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_MUL0: cmd.op = OP_MUL0;
      ST_MUL1: cmd.op = OP_MUL1;
      ST_MUL2: cmd.op = OP_MUL2;
      ST_KROT: cmd.op = OP_KROT;
      ST_HUPD: cmd.op = OP_HUPD;
      ST_FINA: cmd.op = OP_FINA;
      ST_FINB: cmd.op = OP_FINB;
      ST_FOUT: begin
        if (!sts.out_full) begin
          cmd.op = OP_FOUT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/mswh_dp.sv
// ----------------------------------------------------------------------------
// mswh_dp
// datapath: config registers, accumulator, shared 32x32 multiplier, output
// ----------------------------------------------------------------------------
module mswh_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mswh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mswh_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [mswh_pkg::WORD_W-1:0]         in_data_word,
  input  logic                                in_last_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mswh_pkg::HASH_W-1:0]         out_hash_value,
  input  mswh_pkg::dp_cmd_t                   cmd,
  output mswh_pkg::dp_sts_t                   sts
);
  import mswh_pkg::*;

  logic [CFG_W-1:0]  seed_r;
  logic [CFG_W-1:0]  len_r;
  logic              at_start_r;
  logic              last_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] opa_r;
  logic [WORD_W-1:0] prod_r;
  logic [HASH_W-1:0] hash_r;
  logic              out_valid_r;

  logic [WORD_W-1:0]   mul_b;
  logic [HALF_W-1:0]   mul_x;
  logic [HALF_W-1:0]   mul_y;
  logic [WORD_W-1:0]   mul_p;
  logic [HALF_W-1:0]   prod_hi_sum;
  logic [WORD_W-1:0]   k_rot;
  logic [WORD_W-1:0]   h_mix;
  logic [WORD_W-1:0]   h_rot;
  logic [WORD_W-1:0]   h_nxt;
  logic [WORD_W-1:0]   acc_fold;
  logic [WORD_W-1:0]   prod_fold;

  // constant operand of the current multiply
  always_comb begin
    case (cmd.sel)
      SEL_K1:  mul_b = MUL_K1;
      SEL_K2:  mul_b = MUL_K2;
      SEL_M1:  mul_b = FIN_M1;
      default: mul_b = FIN_M2;
    endcase
  end

  // low 64 bits of a 64x64 product over three passes:
  // lo*lo, then lo*hi and hi*lo folded into the upper half
  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        mul_x = opa_r[HALF_W-1:0];
        mul_y = mul_b[WORD_W-1:HALF_W];
      end
      OP_MUL2: begin
        mul_x = opa_r[WORD_W-1:HALF_W];
        mul_y = mul_b[HALF_W-1:0];
      end
      default: begin
        mul_x = opa_r[HALF_W-1:0];
        mul_y = mul_b[HALF_W-1:0];
      end
    endcase
  end

  assign mul_p       = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
  assign prod_hi_sum = prod_r[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];

  assign k_rot     = {prod_r[WORD_W-1-ROT_K:0], prod_r[WORD_W-1:WORD_W-ROT_K]};
  assign h_mix     = acc_r ^ prod_r;
  assign h_rot     = {h_mix[WORD_W-1-ROT_H:0], h_mix[WORD_W-1:WORD_W-ROT_H]};
  assign h_nxt     = {h_rot[WORD_W-3:0], 2'b00} + h_rot + ADD_H;
  assign acc_fold  = acc_r ^ (acc_r >> FIN_SHIFT);
  assign prod_fold = prod_r ^ (prod_r >> FIN_SHIFT);

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      len_r       <= LEN_RESET;
      at_start_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEED: seed_r <= cfg_wdata;
          REG_LEN:  len_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == OP_HUPD) begin
        at_start_r <= last_r;
      end
      if (cmd.op == OP_FOUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        opa_r  <= in_data_word;
        last_r <= in_last_word;
        if (at_start_r) begin
          acc_r <= {{(WORD_W-CFG_W){1'b0}}, seed_r ^ len_r};
        end
      end
      OP_MUL0: prod_r <= mul_p;
      OP_MUL1, OP_MUL2: prod_r[WORD_W-1:HALF_W] <= prod_hi_sum;
      OP_KROT: opa_r  <= k_rot;
      OP_HUPD: acc_r  <= h_nxt;
      OP_FINA: opa_r  <= acc_fold;
      OP_FINB: opa_r  <= prod_fold;
      OP_FOUT: hash_r <= prod_fold[HASH_W-1:0];
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;
  assign sts.last       = last_r;
  assign sts.out_full   = out_valid_r && !out_ready;

endmodule

FILE: rtl/murmur_style_word_hash.sv
// ----------------------------------------------------------------------------
// murmur_style_word_hash
// word-serial murmur3-x64-style hash of 64-bit words, 32-bit result
// ----------------------------------------------------------------------------
// Words of a message are taken one at a time; the first word of a message
// starts the accumulator from seed xor byte_length, and the word flagged
// last runs the fmix64 finalizer and posts the low 32 bits on the result
// channel. All 64-bit multiplies go through one 32x32 multiplier in three
// passes each, so a word that is not last holds in_ready low after its
// transaction until its multiply passes and fixups are done, and a last
// word until the finalizer has also run and any previous hash still
// sitting in the output register has been taken. The output register
// lets the next message start while a hash waits to be taken. seed and
// byte_length are sampled on the first word of each message.
// ----------------------------------------------------------------------------
module murmur_style_word_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [mswh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mswh_pkg::CFG_W-1:0]      cfg_wdata,
  // word input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mswh_pkg::WORD_W-1:0]     in_data_word,
  input  logic                            in_last_word,
  // hash output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mswh_pkg::HASH_W-1:0]     out_hash_value
);
  import mswh_pkg::*;

  // commands from the sequencer, status back from the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one word in flight, walks multiply passes and fixups
  mswh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, shared multiplier, rotate/xor logic, output register
  mswh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_data_word   (in_data_word),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

FILE: rtl/mswh_checker.sv
// ----------------------------------------------------------------------------
// mswh_checker
// port-level checks of the hash block, bound to the top level
// ----------------------------------------------------------------------------
module mswh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [mswh_pkg::HASH_W-1:0]     out_hash_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("result changed or dropped while stalled");

  // one word at a time: ready drops right after a transaction
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  // a hash cannot appear the cycle after a word is taken
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("hash posted too soon after a word");

  // first cycle out of reset: no result pending and input open
  a_reset_state: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind murmur_style_word_hash mswh_checker u_mswh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);
